@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a fixed message
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");

// clocked assertion with reset disable and a caller message
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ design/etab_pkg.sv @@
// types and constants of the ethernet / ip tunnel bridge
package etab_pkg;

    // ethertypes and frame sizes
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam int          ARP_LEN    = 42;
    localparam int          ETH_HDR_LEN = 14;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // fixed part of an ethernet/ipv4 arp request (htype, ptype, hlen, plen, oper)
    localparam logic [7:0] ARP_REQ_HDR [8] = '{
        8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
    };

    // fixed middle of an arp reply (ethertype, htype, ptype, hlen, plen, oper)
    localparam logic [7:0] ARP_REPLY_MID [10] = '{
        8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
    };

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HOST_MAC   = 2'd0,
        CFG_GUEST_MAC  = 2'd1,
        CFG_MAX_IP_LEN = 2'd2,
        CFG_PAUSED     = 2'd3
    } t_cfg_idx;

    // input opcodes
    localparam logic OP_GUEST = 1'b0;
    localparam logic OP_HOST  = 1'b1;

    // output ports
    localparam logic PORT_TUNNEL = 1'b0;
    localparam logic PORT_GUEST  = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_port;
        logic       out_last;
    } t_out;

    // work items handed from front to back
    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_HOST_HDR  = 2'd1,
        KIND_ARP_REPLY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        port;
        logic        last;
        logic        is_v6;
        logic [47:0] src_mac;
        logic [47:0] sender_hw;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } t_cmd;

endpackage

@@ design/etab_queue.sv @@
// small command queue between the classifier and the output sequencer
module etab_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  etab_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output etab_pkg::t_cmd o_head,
    output logic           o_full
);
    import etab_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr;
    logic [QW-1:0]   r_rd_ptr;
    logic [QW:0]     r_count;
    logic [QW:0]     n_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QW+1)'(1);
        end
    end

    // pointers and occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
endmodule

@@ design/etab_front.sv @@
// input classifier: tracks guest frames and host packets, issues output commands
module etab_front #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  etab_pkg::t_in  i_in,
    input  logic           i_paused,
    input  logic [11:0]    i_max_ip_len,
    output logic           o_push,
    output etab_pkg::t_cmd o_cmd
);
    import etab_pkg::*;

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LW = ((CW > 12) ? CW : 12) + 1;

    // guest frame state
    logic [CW-1:0] r_eg_cnt,   n_eg_cnt;
    logic [15:0]   r_type,     n_type;
    logic [47:0]   r_src_mac,  n_src_mac;
    logic [47:0]   r_shw,      n_shw;
    logic [31:0]   r_sip,      n_sip;
    logic [31:0]   r_tip,      n_tip;
    logic          r_arp_ok,   n_arp_ok;
    // host packet state
    logic [CW-1:0] r_in_cnt,   n_in_cnt;
    logic          r_in_drop,  n_in_drop;

    logic [CW-1:0] eg_off;
    logic [LW-1:0] lim;
    logic [LW-1:0] len_ext;
    logic [LW-1:0] max_ext;
    logic [LW-1:0] pos_next;
    logic [3:0]    ver;
    logic          drop;
    logic          pkt_end;
    logic          is_ip;

    assign eg_off  = r_eg_cnt - CW'(ETH_HDR_LEN);
    assign len_ext = LW'(i_max_ip_len);
    assign max_ext = LW'(MAX_PACKET_BYTES);
    assign lim     = (len_ext > max_ext) ? max_ext : len_ext;
    assign pos_next = LW'(r_in_cnt) + LW'(1);
    assign ver     = i_in.in_byte[7:4];
    assign is_ip   = (r_type == ETYPE_IPV4) || (r_type == ETYPE_IPV6);

    // classify one byte and build the command for the back end
    always_comb begin
        n_eg_cnt  = r_eg_cnt;
        n_type    = r_type;
        n_src_mac = r_src_mac;
        n_shw     = r_shw;
        n_sip     = r_sip;
        n_tip     = r_tip;
        n_arp_ok  = r_arp_ok;
        n_in_cnt  = r_in_cnt;
        n_in_drop = r_in_drop;
        drop      = r_in_drop;
        pkt_end   = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;
        o_cmd.data = i_in.in_byte;
        if (i_in.opcode == OP_GUEST) begin
            // capture header and arp fields by position
            if (r_eg_cnt >= 6 && r_eg_cnt < 12) begin
                n_src_mac = {r_src_mac[39:0], i_in.in_byte};
            end else if (r_eg_cnt == 12 || r_eg_cnt == 13) begin
                n_type = {r_type[7:0], i_in.in_byte};
            end else if (r_eg_cnt >= 14 && r_eg_cnt < 22) begin
                if (i_in.in_byte != ARP_REQ_HDR[eg_off[2:0]]) begin
                    n_arp_ok = 1'b0;
                end
            end else if (r_eg_cnt >= 22 && r_eg_cnt < 28) begin
                n_shw = {r_shw[39:0], i_in.in_byte};
            end else if (r_eg_cnt >= 28 && r_eg_cnt < 32) begin
                n_sip = {r_sip[23:0], i_in.in_byte};
            end else if (r_eg_cnt >= 38 && r_eg_cnt < 42) begin
                n_tip = {r_tip[23:0], i_in.in_byte};
            end
            // ip payload toward the tunnel
            if (r_eg_cnt >= 14 && is_ip) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_BYTE;
                o_cmd.port = PORT_TUNNEL;
                o_cmd.last = i_in.in_last;
            end
            if (i_in.in_last) begin
                // arp reply on the final byte of a good request, unless paused
                if (r_eg_cnt >= (ARP_LEN - 1) && r_type == ETYPE_ARP && n_arp_ok
                    && !i_paused) begin
                    o_push          = 1'b1;
                    o_cmd.kind      = KIND_ARP_REPLY;
                    o_cmd.port      = PORT_GUEST;
                    o_cmd.src_mac   = n_src_mac;
                    o_cmd.sender_hw = n_shw;
                    o_cmd.sender_ip = n_sip;
                    o_cmd.target_ip = n_tip;
                end
                n_eg_cnt  = '0;
                n_type    = '0;
                n_src_mac = '0;
                n_shw     = '0;
                n_sip     = '0;
                n_tip     = '0;
                n_arp_ok  = 1'b1;
            end else if (r_eg_cnt < CW'(MAX_PACKET_BYTES)) begin
                n_eg_cnt = r_eg_cnt + CW'(1);
            end
        end else begin
            // host packet: version check on the first byte
            if (r_in_cnt == '0) begin
                drop = !((ver == 4'd4 || ver == 4'd6) && lim != '0);
            end
            if (!drop) begin
                pkt_end = i_in.in_last || (pos_next >= lim);
                if (!i_paused) begin
                    o_push      = 1'b1;
                    o_cmd.kind  = (r_in_cnt == '0) ? KIND_HOST_HDR : KIND_BYTE;
                    o_cmd.port  = PORT_GUEST;
                    o_cmd.last  = pkt_end;
                    o_cmd.is_v6 = (ver == 4'd6);
                end
                if (pkt_end) begin
                    drop = 1'b1;
                end
            end
            n_in_drop = drop;
            if (i_in.in_last) begin
                n_in_cnt  = '0;
                n_in_drop = 1'b0;
            end else if (r_in_cnt < CW'(MAX_PACKET_BYTES)) begin
                n_in_cnt = r_in_cnt + CW'(1);
            end
        end
        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eg_cnt  <= '0;
            r_type    <= '0;
            r_src_mac <= '0;
            r_shw     <= '0;
            r_sip     <= '0;
            r_tip     <= '0;
            r_arp_ok  <= 1'b1;
            r_in_cnt  <= '0;
            r_in_drop <= 1'b0;
        end else if (i_accept) begin
            r_eg_cnt  <= n_eg_cnt;
            r_type    <= n_type;
            r_src_mac <= n_src_mac;
            r_shw     <= n_shw;
            r_sip     <= n_sip;
            r_tip     <= n_tip;
            r_arp_ok  <= n_arp_ok;
            r_in_cnt  <= n_in_cnt;
            r_in_drop <= n_in_drop;
        end
    end
endmodule

@@ design/etab_back.sv @@
// output sequencer: expands commands into bytes and holds the output register
module etab_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  etab_pkg::t_cmd i_head,
    output logic           o_pop,
    input  logic [47:0]    i_host_mac,
    input  logic [47:0]    i_guest_mac,
    output logic           o_out_valid,
    output etab_pkg::t_out o_out_data,
    input  logic           i_out_stall
);
    import etab_pkg::*;

    logic [5:0] r_idx;
    logic [5:0] n_idx;
    logic       r_out_valid;
    t_out       r_out;
    t_out       cur;
    logic       cmd_done;
    logic       advance;
    logic [5:0] off;

    // byte k of a mac, first on the wire first
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // byte k of an ipv4 address
    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

    assign advance = i_head_valid && (!r_out_valid || !i_out_stall);

    // pick the byte at the current position of the head command
    always_comb begin
        cur      = '0;
        cmd_done = 1'b1;
        off      = '0;
        case (i_head.kind)
            KIND_BYTE: begin
                cur.out_byte = i_head.data;
                cur.out_port = i_head.port;
                cur.out_last = i_head.last;
            end
            KIND_HOST_HDR: begin
                cur.out_port = PORT_GUEST;
                cmd_done     = (r_idx == 6'(ETH_HDR_LEN));
                if (r_idx < 6'd6) begin
                    cur.out_byte = mac_byte(i_guest_mac, r_idx[2:0]);
                end else if (r_idx < 6'd12) begin
                    off          = r_idx - 6'd6;
                    cur.out_byte = mac_byte(i_host_mac, off[2:0]);
                end else if (r_idx == 6'd12) begin
                    cur.out_byte = i_head.is_v6 ? ETYPE_IPV6[15:8] : ETYPE_IPV4[15:8];
                end else if (r_idx == 6'd13) begin
                    cur.out_byte = i_head.is_v6 ? ETYPE_IPV6[7:0] : ETYPE_IPV4[7:0];
                end else begin
                    cur.out_byte = i_head.data;
                    cur.out_last = i_head.last;
                end
            end
            KIND_ARP_REPLY: begin
                cur.out_port = PORT_GUEST;
                cmd_done     = (r_idx == 6'(ARP_LEN - 1));
                cur.out_last = cmd_done;
                if (r_idx < 6'd6) begin
                    cur.out_byte = mac_byte(i_head.src_mac, r_idx[2:0]);
                end else if (r_idx < 6'd12) begin
                    off          = r_idx - 6'd6;
                    cur.out_byte = mac_byte(i_host_mac, off[2:0]);
                end else if (r_idx < 6'd22) begin
                    off          = r_idx - 6'd12;
                    cur.out_byte = ARP_REPLY_MID[off[3:0]];
                end else if (r_idx < 6'd28) begin
                    off          = r_idx - 6'd22;
                    cur.out_byte = mac_byte(i_host_mac, off[2:0]);
                end else if (r_idx < 6'd32) begin
                    off          = r_idx - 6'd28;
                    cur.out_byte = ip_byte(i_head.target_ip, off[1:0]);
                end else if (r_idx < 6'd38) begin
                    off          = r_idx - 6'd32;
                    cur.out_byte = mac_byte(i_head.sender_hw, off[2:0]);
                end else begin
                    off          = r_idx - 6'd38;
                    cur.out_byte = ip_byte(i_head.sender_ip, off[1:0]);
                end
            end
            default: begin
                cur = '0;
            end
        endcase
    end

    assign o_pop = advance && cmd_done;

    always_comb begin
        n_idx = r_idx;
        if (advance) begin
            n_idx = cmd_done ? 6'd0 : r_idx + 6'd1;
        end
    end

    // position counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= cur;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

@@ design/ethernet_tun_bridge_arp_responder.sv @@
// top level of the ethernet to ip tunnel bridge with arp responder
// One byte is taken per cycle on the input channel while the command queue
// is not full. Guest frame bytes are classified as they arrive: ipv4/ipv6
// payload leaves toward the tunnel one byte per cycle while the output is
// not stalled, through the command queue and the output register, and a
// good arp request gets a 42-byte reply toward the guest after its final
// byte unless paused. The first byte of a host ip packet expands into 15
// output bytes (ethernet header plus the byte), later bytes pass one per
// cycle while the output is not stalled. Expansion runs in the output
// sequencer, fed by a 4-entry command queue; the input stalls only while
// that queue is full. Configuration is written through a port that is always
// ready and is to be changed only while no transfer is in flight.
module ethernet_tun_bridge_arp_responder #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  etab_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output etab_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [47:0]    i_cfg_data
);
    import etab_pkg::*;

    logic [47:0] r_host_mac;
    logic [47:0] r_guest_mac;
    logic [11:0] r_max_ip_len;
    logic        r_paused;

    logic        accept;
    logic        push;
    t_cmd        push_cmd;
    logic        q_valid;
    logic        q_full;
    t_cmd        q_head;
    logic        pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_mac   <= '0;
            r_guest_mac  <= '0;
            r_max_ip_len <= 12'd1500;
            r_paused     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HOST_MAC:   r_host_mac   <= i_cfg_data;
                CFG_GUEST_MAC:  r_guest_mac  <= i_cfg_data;
                CFG_MAX_IP_LEN: r_max_ip_len <= i_cfg_data[11:0];
                CFG_PAUSED:     r_paused     <= i_cfg_data[0];
                default:        r_paused     <= r_paused;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    etab_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in         (i_in_data),
        .i_paused     (r_paused),
        .i_max_ip_len (r_max_ip_len),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    etab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_full  (q_full)
    );

    etab_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (pop),
        .i_host_mac   (r_host_mac),
        .i_guest_mac  (r_guest_mac),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );
endmodule

@@ design/etab_checker.sv @@
// port level checks of the bridge, bound to the top level
`include "assert_macros.svh"

module etab_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input etab_pkg::t_out o_out_data
);
    // a stalled output transfer keeps its payload
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))

    // input stall only rises right after an accepted input transfer
    `ASSERT_CLK_MSG(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall), "input stall rose without a transfer")

    // nothing is offered in the first cycle after reset
    `ASSERT_CLK_MSG(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_out_valid && !o_in_stall, "output active right after reset")
endmodule

bind ethernet_tun_bridge_arp_responder etab_checker u_etab_checker (.*);

@@ tb/tb_ethernet_tun_bridge_arp_responder.sv @@
// self-checking testbench of the ethernet / ip tunnel bridge with arp responder
module tb_ethernet_tun_bridge_arp_responder;
    import etab_pkg::*;

    localparam int MAX_PKT     = 2048;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 64;

    // fixed arp request words and the fixed middle of a reply
    localparam logic [63:0] ARP_REQ_FIXED = 64'h0001_0800_0604_0001;
    localparam logic [79:0] REPLY_MID     = 80'h0806_0001_0800_0604_0002;

    typedef logic [7:0] t_octets[$];
    typedef enum {
        FRAME_IPV4,
        FRAME_IPV6,
        FRAME_ARP,
        FRAME_ARP_BAD,
        FRAME_OTHER
    } t_frame_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    // stimulus and expected output bytes
    t_in  byte_feed[$];
    t_out bridge_out_q[$];
    int   queued_items;
    int   mismatches;
    int   cycle_count;
    bit   in_took;
    int   in_gap;
    int   out_hold;
    bit   calm;
    bit   quiet;

    // register copies
    logic [47:0] cfg_host_mac;
    logic [47:0] cfg_guest_mac;
    logic [11:0] cfg_max_len;
    logic        cfg_paused;

    // guest frame parse state
    int          g_pos;
    logic [15:0] g_type;
    logic [47:0] g_src_mac;
    logic [47:0] g_arp_hw;
    logic [31:0] g_arp_sip;
    logic [31:0] g_arp_tip;
    logic        g_arp_ok;

    // host packet state
    int          h_pos;
    logic        h_drop;

    ethernet_tun_bridge_arp_responder #(
        .MAX_PACKET_BYTES(MAX_PKT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void expect_byte(logic [7:0] b, logic port, logic last);
        t_out r;
        r.out_byte = b;
        r.out_port = port;
        r.out_last = last;
        bridge_out_q.push_back(r);
    endfunction

    function automatic void guest_frame_clear();
        g_pos     = 0;
        g_type    = '0;
        g_src_mac = '0;
        g_arp_hw  = '0;
        g_arp_sip = '0;
        g_arp_tip = '0;
        g_arp_ok  = 1'b1;
    endfunction

    // predicted bridge behavior for one accepted byte
    function automatic void bridge_predict(t_in it);
        int          i;
        int          k;
        int          lim;
        logic [7:0]  b;
        logic [3:0]  ver;
        logic [15:0] ety;
        logic        eop;
        b = it.in_byte;
        if (it.opcode == OP_GUEST) begin
            i = g_pos;
            if (i >= 6 && i < 12) begin
                g_src_mac = {g_src_mac[39:0], b};
            end else if (i == 12 || i == 13) begin
                g_type = {g_type[7:0], b};
            end else if (i >= 14 && i < 22) begin
                if (b != ARP_REQ_FIXED[63 - 8 * (i - 14) -: 8]) g_arp_ok = 1'b0;
            end else if (i >= 22 && i < 28) begin
                g_arp_hw = {g_arp_hw[39:0], b};
            end else if (i >= 28 && i < 32) begin
                g_arp_sip = {g_arp_sip[23:0], b};
            end else if (i >= 38 && i < 42) begin
                g_arp_tip = {g_arp_tip[23:0], b};
            end
            // ip payload streams to the tunnel
            if (i >= 14 && (g_type == ETYPE_IPV4 || g_type == ETYPE_IPV6))
                expect_byte(b, PORT_TUNNEL, it.in_last);
            if (it.in_last) begin
                // arp reply with swapped addresses
                if (i >= 41 && g_type == ETYPE_ARP && g_arp_ok && !cfg_paused) begin
                    for (k = 0; k < 6; k++) expect_byte(g_src_mac[47 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 6; k++) expect_byte(cfg_host_mac[47 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 10; k++) expect_byte(REPLY_MID[79 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 6; k++) expect_byte(cfg_host_mac[47 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 4; k++) expect_byte(g_arp_tip[31 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 6; k++) expect_byte(g_arp_hw[47 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 4; k++) expect_byte(g_arp_sip[31 - 8 * k -: 8], PORT_GUEST, k == 3);
                end
                guest_frame_clear();
            end else if (g_pos < MAX_PKT) begin
                g_pos++;
            end
        end else begin
            lim = (cfg_max_len > MAX_PKT) ? MAX_PKT : int'(cfg_max_len);
            if (h_pos == 0) begin
                ver    = b[7:4];
                h_drop = !((ver == 4'd4 || ver == 4'd6) && lim > 0);
                if (!h_drop && !cfg_paused) begin
                    ety = (ver == 4'd4) ? ETYPE_IPV4 : ETYPE_IPV6;
                    for (k = 0; k < 6; k++) expect_byte(cfg_guest_mac[47 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    for (k = 0; k < 6; k++) expect_byte(cfg_host_mac[47 - 8 * k -: 8], PORT_GUEST, 1'b0);
                    expect_byte(ety[15:8], PORT_GUEST, 1'b0);
                    expect_byte(ety[7:0], PORT_GUEST, 1'b0);
                end
            end
            // payload, cut at the length limit
            if (!h_drop) begin
                eop = it.in_last || (h_pos + 1 >= lim);
                if (!cfg_paused) expect_byte(b, PORT_GUEST, eop);
                if (eop) h_drop = 1'b1;
            end
            if (it.in_last) begin
                h_pos  = 0;
                h_drop = 1'b0;
            end else if (h_pos < MAX_PKT) begin
                h_pos++;
            end
        end
    endfunction

    function automatic void check_result(t_out got);
        t_out want;
        if (bridge_out_q.size() == 0) begin
            $error("unexpected output byte %02h port %0d last %0d",
                   got.out_byte, got.out_port, got.out_last);
            mismatches++;
            return;
        end
        want = bridge_out_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %02h actual %02h", want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.out_port !== want.out_port) begin
            $error("out_port expected %0d actual %0d", want.out_port, got.out_port);
            mismatches++;
        end
        if (got.out_last !== want.out_last) begin
            $error("out_last expected %0d actual %0d", want.out_last, got.out_last);
            mismatches++;
        end
    endfunction

    // monitor: input and output transfers at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) bridge_predict(i_in_data);
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
        end
    end

    // driver: next byte once the current one has transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
                in_gap     <= $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else if (byte_feed.size() != 0) begin
                i_in_data  <= byte_feed.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure in short bursts
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold    <= out_hold - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            out_hold    <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // cycle limit, and stretches without idling
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 50 == 0) quiet <= ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ethernet_tun_bridge_arp_responder regression: fail");
            $finish;
        end
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic t_octets guest_frame(t_frame_kind kind, int len);
        t_octets     f;
        logic [15:0] ety;
        logic [7:0]  flip;
        int          k;
        int          bad;
        for (k = 0; k < len; k++) f.push_back(8'($urandom_range(0, 255)));
        case (kind)
            FRAME_IPV4:  ety = ETYPE_IPV4;
            FRAME_IPV6:  ety = ETYPE_IPV6;
            FRAME_OTHER: ety = 16'($urandom);
            default:     ety = ETYPE_ARP;
        endcase
        if (len > 12) f[12] = ety[15:8];
        if (len > 13) f[13] = ety[7:0];
        if (kind == FRAME_ARP || kind == FRAME_ARP_BAD) begin
            for (k = 0; k < 8 && 14 + k < len; k++) f[14 + k] = ARP_REQ_FIXED[63 - 8 * k -: 8];
            // one wrong bit in the fixed request fields
            if (kind == FRAME_ARP_BAD) begin
                bad  = $urandom_range(14, 21);
                flip = 8'h01 << $urandom_range(0, 7);
                if (bad < len) f[bad] = f[bad] ^ flip;
            end
        end
        return f;
    endfunction

    function automatic t_octets host_packet(logic [3:0] ver, int len);
        t_octets f;
        int      k;
        for (k = 0; k < len; k++) f.push_back(8'($urandom_range(0, 255)));
        f[0] = {ver, 4'($urandom_range(0, 15))};
        return f;
    endfunction

    // interleave one guest frame with one host packet
    task automatic send_frames(input t_octets gq, input t_octets hq, input bit host_open);
        int  gi;
        int  hi;
        t_in it;
        gi = 0;
        hi = 0;
        while (gi < gq.size() || hi < hq.size()) begin
            if (hi >= hq.size() || (gi < gq.size() && $urandom_range(0, 1) == 1)) begin
                it.opcode  = OP_GUEST;
                it.in_byte = gq[gi];
                it.in_last = (gi == gq.size() - 1);
                gi++;
            end else begin
                it.opcode  = OP_HOST;
                it.in_byte = hq[hi];
                it.in_last = (hi == hq.size() - 1) && !host_open;
                hi++;
            end
            byte_feed.push_back(it);
            queued_items++;
        end
    endtask

    // wait for every byte to transfer and every expected output to arrive
    task automatic settle();
        do @(posedge i_clk);
        while (byte_feed.size() != 0 || i_in_valid || bridge_out_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_HOST_MAC:   cfg_host_mac  = val;
            CFG_GUEST_MAC:  cfg_guest_mac = val;
            CFG_MAX_IP_LEN: cfg_max_len   = val[11:0];
            CFG_PAUSED:     cfg_paused    = val[0];
            default:        ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random mix of frames and packets
    task automatic random_traffic(input int n_items);
        t_octets    gq;
        t_octets    hq;
        t_octets    none;
        int         stop_at;
        int         r;
        logic [3:0] ver;
        stop_at = queued_items + n_items;
        while (queued_items < stop_at) begin
            r = $urandom_range(0, 19);
            if (r < 7)       gq = guest_frame(FRAME_ARP, $urandom_range(42, 48));
            else if (r < 8)  gq = guest_frame(FRAME_ARP, $urandom_range(20, 41));
            else if (r < 10) gq = guest_frame(FRAME_ARP_BAD, $urandom_range(42, 46));
            else if (r < 13) gq = guest_frame(FRAME_IPV4, $urandom_range(14, 36));
            else if (r < 15) gq = guest_frame(FRAME_IPV6, $urandom_range(14, 36));
            else if (r < 17) gq = guest_frame(FRAME_OTHER, $urandom_range(14, 30));
            else if (r < 18) gq = guest_frame(FRAME_IPV4, $urandom_range(1, 13));
            else             gq = none;
            r = $urandom_range(0, 9);
            if (r < 4)      ver = 4'd4;
            else if (r < 8) ver = 4'd6;
            else            ver = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 4) == 0) hq = none;
            else                           hq = host_packet(ver, $urandom_range(1, 24));
            send_frames(gq, hq, 1'b0);
        end
    endtask

    initial begin
        t_octets none;
        t_octets hq;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_HOST_MAC;
        i_cfg_data   = '0;
        queued_items = 0;
        mismatches   = 0;
        cycle_count  = 0;
        in_took      = 1'b0;
        in_gap       = 0;
        out_hold     = 0;
        calm         = 1'b0;
        quiet        = 1'b0;
        cfg_host_mac  = '0;
        cfg_guest_mac = '0;
        cfg_max_len   = 12'd1500;
        cfg_paused    = 1'b0;
        guest_frame_clear();
        h_pos  = 0;
        h_drop = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: bare ip frame, short frame, each host version
        send_frames(guest_frame(FRAME_IPV4, 14), host_packet(4'd4, 2), 1'b0);
        send_frames(guest_frame(FRAME_OTHER, 3), host_packet(4'd6, 1), 1'b0);
        send_frames(none, host_packet(4'd15, 2), 1'b0);
        settle();

        // all-ones and all-zero addresses
        write_reg(CFG_HOST_MAC, 48'hffff_ffff_ffff);
        write_reg(CFG_GUEST_MAC, 48'h0);
        send_frames(guest_frame(FRAME_ARP, 42), host_packet(4'd4, 3), 1'b0);
        settle();

        // pause toggled inside a host packet, arp request while paused
        write_reg(CFG_HOST_MAC, rand_mac());
        write_reg(CFG_GUEST_MAC, 48'hffff_ffff_ffff);
        hq = host_packet(4'd4, 9);
        send_frames(none, hq[0:3], 1'b1);
        settle();
        write_reg(CFG_PAUSED, 48'd1);
        send_frames(guest_frame(FRAME_ARP, 44), hq[4:6], 1'b1);
        settle();
        write_reg(CFG_PAUSED, 48'd0);
        send_frames(none, hq[7:8], 1'b0);
        settle();

        // normal traffic
        write_reg(CFG_GUEST_MAC, rand_mac());
        random_traffic(30);
        settle();

        // truncation at small limits
        write_reg(CFG_MAX_IP_LEN, 48'd1);
        random_traffic(10);
        settle();
        write_reg(CFG_MAX_IP_LEN, 48'($urandom_range(2, 20)));
        random_traffic(15);
        settle();

        // paused: nothing reaches the guest
        write_reg(CFG_PAUSED, 48'd1);
        random_traffic(15);
        settle();
        write_reg(CFG_PAUSED, 48'd0);

        // zero limit drops every host packet
        write_reg(CFG_MAX_IP_LEN, 48'd0);
        random_traffic(10);
        settle();

        // closing stretch without idling, oversized limit is clamped
        write_reg(CFG_MAX_IP_LEN, 48'hfff);
        write_reg(CFG_HOST_MAC, 48'h0);
        calm = 1'b1;
        random_traffic(20);
        settle();

        if (mismatches == 0) begin
            $display("ethernet_tun_bridge_arp_responder regression: pass");
        end else begin
            $display("ethernet_tun_bridge_arp_responder regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/etab_pkg.sv
design/etab_queue.sv
design/etab_front.sv
design/etab_back.sv
design/ethernet_tun_bridge_arp_responder.sv
design/etab_checker.sv
tb/tb_ethernet_tun_bridge_arp_responder.sv
